[design/flc2d_pkg.sv]
`default_nettype none

package flc2d_pkg;

    localparam int MAX_DIM     = 16;
    localparam int DATA_BITS   = 16;
    localparam int RESULT_BITS = 40;
    localparam int SAMPLE_BITS = 16;
    localparam int CMD_BITS    = 2;
    localparam int POS_BITS    = 5;
    localparam int CFG_BITS    = 5;
    localparam int CFG_IDX_BITS = 2;

    localparam int IDX_BITS  = $clog2(MAX_DIM);
    localparam int DIM_BITS  = $clog2(MAX_DIM + 1);
    localparam int ADDR_BITS = 2 * IDX_BITS;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int PROD_BITS = 2 * DATA_BITS;
    localparam int DIFF_BITS = ((POS_BITS > IDX_BITS) ? POS_BITS : IDX_BITS) + 1;

    localparam logic [CMD_BITS-1:0] CMD_WRITE_A = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_WRITE_B = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_READ    = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_B_COLS = 2'd3;

    typedef struct packed {
        logic [CMD_BITS-1:0]           cmd;
        logic [POS_BITS-1:0]           row;
        logic [POS_BITS-1:0]           col;
        logic signed [SAMPLE_BITS-1:0] sample;
    } req_t;

    typedef struct packed {
        logic signed [RESULT_BITS-1:0] result;
        logic                          status;
    } rsp_t;

    // A shape of zero acts as one, and anything above the store size saturates.
    function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [CFG_BITS-1:0] v);
        logic [DIM_BITS-1:0] d;
        if (v == '0)
            d = DIM_BITS'(1);
        else if (int'(v) > MAX_DIM)
            d = DIM_BITS'(MAX_DIM);
        else
            d = DIM_BITS'(v);
        return d;
    endfunction

endpackage

`default_nettype wire

[design/full_linear_convolution_2d_top.sv]
`default_nettype none

// Full 2-D linear convolution engine. Operand shapes are set through the
// configuration port; write requests store one sample of A or B and answer in
// the next cycle, and out-of-shape indexes or unknown commands answer at once
// with status 1. A read request walks every (i, j) of operand A with one shared
// multiply-accumulate unit, one product per cycle. The block holds one request
// at a time; request ready is low while a read is being summed.
module full_linear_convolution_2d_top (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    input  wire logic                                     req_valid,
    output logic                                          req_ready,
    input  wire flc2d_pkg::req_t                          req,
    output logic                                          rsp_valid,
    input  wire logic                                     rsp_ready,
    output flc2d_pkg::rsp_t                               rsp,
    input  wire logic                                     cfg_we,
    input  wire logic [flc2d_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  wire logic [flc2d_pkg::CFG_BITS-1:0]           cfg_wdata
);

    localparam int IDX_BITS  = flc2d_pkg::IDX_BITS;
    localparam int DIM_BITS  = flc2d_pkg::DIM_BITS;
    localparam int ADDR_BITS = flc2d_pkg::ADDR_BITS;
    localparam int DATA_BITS = flc2d_pkg::DATA_BITS;
    localparam int PROD_BITS = flc2d_pkg::PROD_BITS;
    localparam int RES_BITS  = flc2d_pkg::RESULT_BITS;
    localparam int POS_BITS  = flc2d_pkg::POS_BITS;
    localparam int DIFF_BITS = flc2d_pkg::DIFF_BITS;
    localparam int SUM_BITS  = DIM_BITS + 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [flc2d_pkg::CFG_BITS-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [DIM_BITS-1:0] ar, ac, br, bc;

    logic [1:0] state_reg, state_next;
    logic [IDX_BITS-1:0] i_reg, i_next, j_reg, j_next;
    logic [POS_BITS-1:0] rd_row_reg, rd_col_reg;

    logic signed [DATA_BITS-1:0] a_mem [flc2d_pkg::DEPTH];
    logic signed [DATA_BITS-1:0] b_mem [flc2d_pkg::DEPTH];
    logic signed [DATA_BITS-1:0] a_q_reg, b_q_reg;

    logic p1_vld_reg, p1_use_reg, p2_vld_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [RES_BITS-1:0]  acc_reg, acc_next;

    logic rsp_valid_reg;
    flc2d_pkg::rsp_t rsp_reg;

    logic accept;
    logic wr_a, wr_b;
    logic [ADDR_BITS-1:0] wr_addr, a_addr, b_addr;
    logic signed [DATA_BITS-1:0] wr_data;
    logic a_fit, b_fit, out_fit;
    logic [SUM_BITS-1:0] out_rows, out_cols;
    logic [DIFF_BITS-1:0] dr, dc;
    logic pair_use, last_pair, issue;

    assign ar = flc2d_pkg::clamp_dim(a_rows_reg);
    assign ac = flc2d_pkg::clamp_dim(a_cols_reg);
    assign br = flc2d_pkg::clamp_dim(b_rows_reg);
    assign bc = flc2d_pkg::clamp_dim(b_cols_reg);

    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign a_fit = (int'(req.row) < int'(ar)) && (int'(req.col) < int'(ac));
    assign b_fit = (int'(req.row) < int'(br)) && (int'(req.col) < int'(bc));
    assign out_rows = SUM_BITS'(ar) + SUM_BITS'(br) - SUM_BITS'(1);
    assign out_cols = SUM_BITS'(ac) + SUM_BITS'(bc) - SUM_BITS'(1);
    assign out_fit = (int'(req.row) < int'(out_rows)) && (int'(req.col) < int'(out_cols));

    assign wr_a    = accept && (req.cmd == flc2d_pkg::CMD_WRITE_A) && a_fit;
    assign wr_b    = accept && (req.cmd == flc2d_pkg::CMD_WRITE_B) && b_fit;
    assign wr_addr = {req.row[IDX_BITS-1:0], req.col[IDX_BITS-1:0]};
    assign wr_data = DATA_BITS'(req.sample);

    // B index for the current A element; a negative or too large offset means
    // the pair does not contribute.
    assign dr = DIFF_BITS'(rd_row_reg) - DIFF_BITS'(i_reg);
    assign dc = DIFF_BITS'(rd_col_reg) - DIFF_BITS'(j_reg);
    assign pair_use = !dr[DIFF_BITS-1] && (dr < DIFF_BITS'(br))
                   && !dc[DIFF_BITS-1] && (dc < DIFF_BITS'(bc));
    assign a_addr = {i_reg, j_reg};
    assign b_addr = {dr[IDX_BITS-1:0], dc[IDX_BITS-1:0]};
    assign issue  = (state_reg == ST_RUN);
    assign last_pair = (DIM_BITS'(i_reg) == ar - DIM_BITS'(1))
                    && (DIM_BITS'(j_reg) == ac - DIM_BITS'(1));

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.cmd == flc2d_pkg::CMD_READ) && out_fit)
                begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    j_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (last_pair)
                begin
                    state_next = ST_DRAIN;
                end
                else if (DIM_BITS'(j_reg) == ac - DIM_BITS'(1))
                begin
                    j_next = '0;
                    i_next = i_reg + IDX_BITS'(1);
                end
                else
                begin
                    j_next = j_reg + IDX_BITS'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!p1_vld_reg && !p2_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (accept)
            acc_next = '0;
        else if (p2_vld_reg)
            acc_next = acc_reg + RES_BITS'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg    <= flc2d_pkg::CFG_BITS'(1);
            a_cols_reg    <= flc2d_pkg::CFG_BITS'(1);
            b_rows_reg    <= flc2d_pkg::CFG_BITS'(1);
            b_cols_reg    <= flc2d_pkg::CFG_BITS'(1);
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            p1_vld_reg    <= 1'b0;
            p2_vld_reg    <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    flc2d_pkg::CFG_A_ROWS: a_rows_reg <= cfg_wdata;
                    flc2d_pkg::CFG_A_COLS: a_cols_reg <= cfg_wdata;
                    flc2d_pkg::CFG_B_ROWS: b_rows_reg <= cfg_wdata;
                    flc2d_pkg::CFG_B_COLS: b_cols_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            p1_vld_reg <= issue;
            p2_vld_reg <= p1_vld_reg;
            if (accept && !((req.cmd == flc2d_pkg::CMD_READ) && out_fit))
                rsp_valid_reg <= 1'b1;
            else if ((state_reg == ST_DRAIN) && !p1_vld_reg && !p2_vld_reg)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_row_reg <= accept ? req.row : rd_row_reg;
        rd_col_reg <= accept ? req.col : rd_col_reg;
        p1_use_reg <= pair_use;
        prod_reg   <= p1_use_reg ? PROD_BITS'(a_q_reg * b_q_reg) : '0;
        acc_reg    <= acc_next;
        if (accept)
        begin
            rsp_reg.result <= '0;
            unique case (req.cmd)
                flc2d_pkg::CMD_WRITE_A: rsp_reg.status <= !a_fit;
                flc2d_pkg::CMD_WRITE_B: rsp_reg.status <= !b_fit;
                flc2d_pkg::CMD_READ:    rsp_reg.status <= !out_fit;
                default:                rsp_reg.status <= 1'b1;
            endcase
        end
        else if ((state_reg == ST_DRAIN) && !p1_vld_reg && !p2_vld_reg)
        begin
            rsp_reg.result <= acc_reg;
            rsp_reg.status <= 1'b0;
        end
    end

    // Operand stores: one write port shared by requests, one read port each for
    // the accumulation walk.
    always_ff @(posedge clk)
    begin
        if (wr_a)
            a_mem[wr_addr] <= wr_data;
        if (wr_b)
            b_mem[wr_addr] <= wr_data;
        a_q_reg <= a_mem[a_addr];
        b_q_reg <= b_mem[b_addr];
    end

endmodule

`default_nettype wire
